@@ hw/rtl/crc16_packet_framer_unit_assert.svh @@
// Assertion macros for the packet framer.
`ifndef CRC16_PACKET_FRAMER_UNIT_ASSERT_SVH
`define CRC16_PACKET_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cpf_pkg.sv @@
`timescale 1ns / 1ps

package cpf_pkg;

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_MSB    = 16'h8000;

  // Byte positions inside one item's output sequence
  localparam logic [2:0] POS_START  = 3'd0;
  localparam logic [2:0] POS_SEQ_HI = 3'd1;
  localparam logic [2:0] POS_SEQ_LO = 3'd2;
  localparam logic [2:0] POS_DATA   = 3'd3;
  localparam logic [2:0] POS_CRC_HI = 3'd4;
  localparam logic [2:0] POS_CRC_LO = 3'd5;

  // Wait after a sequence change until the header CRC is valid
  localparam logic [1:0] HDR_WAIT = 2'd2;

  // Everything needed to emit the bytes caused by one input word
  typedef struct packed {
    logic        first;
    logic        eop;
    logic [15:0] seq;
    logic [7:0]  data;
    logic [15:0] crc;
  } cpf_rec_t;

  // Framer state seen by the top level
  typedef struct packed {
    logic in_pkt;
    logic hdr_ready;
  } cpf_stat_t;

  // One bytewise CRC-16/XMODEM step, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/cpf_step.sv @@
`timescale 1ns / 1ps

module cpf_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data,
  input  logic              eop,
  output cpf_pkg::cpf_rec_t rec,
  output cpf_pkg::cpf_stat_t stat
);
  import cpf_pkg::*;

  logic [15:0] seq;
  logic [15:0] crc;
  logic        in_pkt;
  logic [1:0]  hdr_wait;
  logic [15:0] hdr_mid;
  logic [7:0]  seq_lo_d;
  logic [15:0] hdr_crc;
  logic [15:0] crc_base;
  logic [15:0] crc_next;

  // Fold this word into the open packet, or into the header CRC on a first word
  assign crc_base = in_pkt ? crc : hdr_crc;
  assign crc_next = crc_feed(crc_base, data);

  assign rec.first = !in_pkt;
  assign rec.eop   = eop;
  assign rec.seq   = seq;
  assign rec.data  = data;
  assign rec.crc   = crc_next;

  assign stat.in_pkt    = in_pkt;
  assign stat.hdr_ready = in_pkt || (hdr_wait == 2'd0);

  // Advance packet state on each taken word; count down the header wait otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= 16'h0000;
      crc      <= 16'h0000;
      in_pkt   <= 1'b0;
      hdr_wait <= HDR_WAIT;
    end else begin
      if (take) begin
        if (eop) begin
          seq      <= seq + 16'h0001;
          crc      <= 16'h0000;
          in_pkt   <= 1'b0;
          hdr_wait <= HDR_WAIT;
        end else begin
          crc    <= crc_next;
          in_pkt <= 1'b1;
        end
      end else if (hdr_wait != 2'd0) begin
        hdr_wait <= hdr_wait - 2'd1;
      end
    end
  end

  // Recompute the header CRC of the current sequence number in two steps
  always_ff @(posedge clk) begin
    hdr_mid  <= crc_feed(16'h0000, seq[15:8]);
    seq_lo_d <= seq[7:0];
    hdr_crc  <= crc_feed(hdr_mid, seq_lo_d);
  end

endmodule

@@ hw/rtl/cpf_emit.sv @@
`timescale 1ns / 1ps

module cpf_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cpf_pkg::cpf_rec_t rec_in,
  output logic              can_load,
  output logic [7:0]        frame_byte,
  output logic              frame_last,
  output logic              frame_valid,
  input  logic              frame_ready
);
  import cpf_pkg::*;

  cpf_rec_t   rec;
  logic       busy;
  logic [2:0] pos;
  logic       out_free;
  logic       shift;
  logic       at_end;
  logic [7:0] sel_byte;

  assign out_free = !frame_valid || frame_ready;
  assign shift    = busy && out_free;
  assign at_end   = (pos == (rec.eop ? POS_CRC_LO : POS_DATA));
  assign can_load = !busy || (shift && at_end);

  // Pick the byte for the current position
  always_comb begin
    unique case (pos)
      POS_START:  sel_byte = START_BYTE;
      POS_SEQ_HI: sel_byte = rec.seq[15:8];
      POS_SEQ_LO: sel_byte = rec.seq[7:0];
      POS_DATA:   sel_byte = rec.data;
      POS_CRC_HI: sel_byte = rec.crc[15:8];
      POS_CRC_LO: sel_byte = rec.crc[7:0];
      default:    sel_byte = 8'h00;
    endcase
  end

  // Hold the record and walk its positions
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_START;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= rec_in.first ? POS_START : POS_DATA;
    end else if (shift && at_end) begin
      busy <= 1'b0;
    end else if (shift) begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

  // Output register: drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (shift) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      frame_byte <= sel_byte;
      frame_last <= (pos == POS_CRC_LO);
    end
  end

endmodule

@@ hw/rtl/crc16_packet_framer_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                      Fields
// payload   payload_valid / payload_ready  payload_byte, end_of_packet
// frame     frame_valid / frame_ready      frame_byte, frame_last
//
// One output word per cycle while frame_ready is high. An input word gives 1 to 6
// output words; the next waits in the input register until the last is sent, so
// middle payload words run at 1/cycle. An input word's first output word passes
// the record register, then the output register. After an end-of-packet word the
// next sequence number's header CRC is rebuilt via hdr_mid, then hdr_crc,
// overlapped with the checksum words. rst is synchronous: sequence 0, no open
// packet. A stalled output holds its word while earlier stages keep filling.

module crc16_packet_framer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       payload_valid,
  output logic       payload_ready,
  input  logic [7:0] payload_byte,
  input  logic       end_of_packet,
  output logic       frame_valid,
  input  logic       frame_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last
);
  import cpf_pkg::*;

`include "crc16_packet_framer_unit_assert.svh"

  logic      ir_valid;
  logic [7:0] ir_data;
  logic      ir_eop;
  logic      em_can_load;
  logic      move;
  cpf_rec_t  rec;
  cpf_stat_t stat;

  assign move          = ir_valid && em_can_load && stat.hdr_ready;
  assign payload_ready = !ir_valid || move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (payload_ready) begin
      ir_valid <= payload_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (payload_valid && payload_ready) begin
      ir_data <= payload_byte;
      ir_eop  <= end_of_packet;
    end
  end

  cpf_step u_step (
    .clk  (clk),
    .rst  (rst),
    .take (move),
    .data (ir_data),
    .eop  (ir_eop),
    .rec  (rec),
    .stat (stat)
  );

  cpf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (move),
    .rec_in      (rec),
    .can_load    (em_can_load),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready)
  );

  // A stalled input word stays in the register
  `CPF_ASSERT_NEXT(a_ir_hold, ir_valid && !payload_ready, ir_valid && $stable({ir_data, ir_eop}), "stalled word lost")

  // An end-of-packet word closes the packet
  `CPF_ASSERT_NEXT(a_eop_close, move && ir_eop, !stat.in_pkt, "packet still open after its last word")

  // Header CRC is being rebuilt right after a packet closes
  `CPF_ASSERT_NEXT(a_hdr_wait, $fell(stat.in_pkt), !stat.hdr_ready, "header CRC ready too early")

endmodule

@@ verif/crc16_packet_framer_unit_tb.sv @@
`timescale 1ns / 1ps

module crc16_packet_framer_unit_tb;

  localparam logic [7:0]  FRM_START = 8'h02;
  localparam logic [15:0] FRM_POLY  = 16'h1021;

  typedef struct {
    logic [7:0] fbyte;
    logic       flast;
  } frame_word_t;

  logic       clk;
  logic       rst;
  logic       payload_valid = 1'b0;
  logic       payload_ready;
  logic [7:0] payload_byte = 8'h00;
  logic       end_of_packet = 1'b0;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;

  // Framer state as predicted from the accepted payload words
  logic [15:0] seq_num;
  logic [15:0] crc_acc;
  logic        pkt_open;

  frame_word_t pending_frame_q[$];
  frame_word_t got_w;
  int          mismatch_count;
  bit          sender_idle_en;
  bit          sink_idle_en;

  crc16_packet_framer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .payload_valid (payload_valid),
    .payload_ready (payload_ready),
    .payload_byte  (payload_byte),
    .end_of_packet (end_of_packet),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame_byte    (frame_byte),
    .frame_last    (frame_last)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // CRC-16/XMODEM, one data bit at a time, MSB first
  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? FRM_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void push_frame_word(input logic [7:0] b, input logic l);
    frame_word_t w;
    w.fbyte = b;
    w.flast = l;
    pending_frame_q.push_back(w);
  endfunction

  // Work out the frame words that one accepted payload word produces
  function automatic void frame_predict(input logic [7:0] b, input logic eop);
    if (!pkt_open) begin
      push_frame_word(FRM_START, 1'b0);
      push_frame_word(seq_num[15:8], 1'b0);
      push_frame_word(seq_num[7:0], 1'b0);
      crc_acc = crc_xmodem_byte(crc_xmodem_byte(16'h0000, seq_num[15:8]), seq_num[7:0]);
      pkt_open = 1'b1;
    end
    push_frame_word(b, 1'b0);
    crc_acc = crc_xmodem_byte(crc_acc, b);
    if (eop) begin
      push_frame_word(crc_acc[15:8], 1'b0);
      push_frame_word(crc_acc[7:0], 1'b1);
      seq_num = seq_num + 16'd1;
      crc_acc = 16'h0000;
      pkt_open = 1'b0;
    end
  endfunction

  // Present one payload word and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic eop);
    logic acc;
    payload_valid <= 1'b1;
    payload_byte  <= b;
    end_of_packet <= eop;
    do begin
      @(negedge clk);
      acc = payload_ready;
      @(posedge clk);
    end while (acc !== 1'b1);
    frame_predict(b, eop);
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_gap();
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      payload_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected frame word has come out
  task automatic drain_frames();
    payload_valid <= 1'b0;
    while (pending_frame_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] bytes[$]);
    for (int k = 0; k < bytes.size(); k++) begin
      send_word(bytes[k], k == bytes.size() - 1);
      maybe_gap();
    end
  endtask

  // Sink side: random stall bursts on frame_ready
  initial begin
    frame_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        frame_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        frame_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted frame word with the oldest expected one
  always @(negedge clk) begin
    if (rst === 1'b0 && frame_valid === 1'b1 && frame_ready === 1'b1) begin
      if (pending_frame_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected frame word: byte=%02h last=%0b",
                   $realtime, frame_byte, frame_last);
      end else begin
        got_w = pending_frame_q.pop_front();
        if (frame_byte !== got_w.fbyte || frame_last !== got_w.flast) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] frame word mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     $realtime, got_w.fbyte, got_w.flast, frame_byte, frame_last);
        end
      end
    end
  end

  // Single-byte packets at the byte extremes and other edge patterns
  task automatic test_single_byte_packets();
    logic [7:0] vals[$];
    vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h01};
    foreach (vals[i]) begin
      send_word(vals[i], 1'b1);
      maybe_gap();
    end
  endtask

  // Multi-byte packets: header, middle words and checksum
  task automatic test_multi_byte_packets();
    send_packet('{8'h00, 8'hFF});
    send_packet('{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F});
    send_packet('{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0});
  endtask

  // Random packets, mostly short, a few long, idling switched per packet
  task automatic test_random_packets(input int n_items);
    logic [7:0] bytes[$];
    int         sent;
    int         plen;
    int         mode;
    bit         drained;
    sent = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 4);
      sender_idle_en = (mode == 1 || mode == 3 || mode == 4);
      sink_idle_en   = (mode == 2 || mode == 3 || mode == 4);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
      bytes.delete();
      repeat (plen) bytes.push_back(8'($urandom_range(0, 255)));
      send_packet(bytes);
      sent += plen;
      if ((!drained && sent >= n_items / 2) || $urandom_range(0, 15) == 0) begin
        drain_frames();
        drained = 1'b1;
      end
    end
  endtask

  // Back-to-back packets with no idling on either side
  task automatic test_back_to_back();
    logic [7:0] bytes[$];
    sender_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    repeat (5) send_word(8'($urandom_range(0, 255)), 1'b1);
    for (int plen = 3; plen <= 7; plen += 2) begin
      bytes.delete();
      repeat (plen) bytes.push_back(8'($urandom_range(0, 255)));
      send_packet(bytes);
    end
  endtask

  // Main sequence
  initial begin
    rst = 1'b1;
    seq_num = 16'h0000;
    crc_acc = 16'h0000;
    pkt_open = 1'b0;
    mismatch_count = 0;
    sender_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_packets();
    test_multi_byte_packets();
    test_random_packets(160);
    test_back_to_back();

    payload_valid <= 1'b0;
    while (pending_frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
